@@ rtl/gn3d_pkg.sv @@
// shared constants, types and fixed-point helpers for the 3d gradient noise unit
// no dependencies
package gn3d_pkg;

    localparam int TableBits = 8;
    localparam int TableSize = 1 << TableBits;
    localparam int FracBits  = 16;
    localparam int CoordW    = 24;
    localparam int OutW      = 18;
    localparam int ValW      = 24;   // internal signed values, |v| < 2^20
    localparam int PipeDepth = 11;   // core stages from accept to result register

    typedef logic [TableBits-1:0] idx_t;
    typedef logic signed [FracBits+1:0] frac_t;   // fraction or fraction minus one
    typedef logic signed [ValW-1:0] val_t;

    localparam val_t OutMax = val_t'((1 << (OutW - 1)) - 1);
    localparam val_t OutMin = val_t'(-(1 << (OutW - 1)));

    localparam logic MODE_EVAL  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // round a product by 2^FracBits, ties toward plus infinity
    function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] p);
        logic signed [47:0] s;
        begin
            s = p + (48'sd1 <<< (FracBits - 1));
            rnd_shift = s >>> FracBits;
        end
    endfunction

    function automatic val_t grad(input logic [3:0] h, input val_t x, input val_t y,
                                  input val_t z);
        val_t u;
        val_t v;
        begin
            u = (h < 4'd8) ? x : y;
            v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
            grad = (h[0] ? -u : u) + (h[1] ? -v : v);
        end
    endfunction

endpackage

@@ rtl/gn3d_fade.sv @@
// quintic fade pipeline, four register stages
// depends on gn3d_pkg
module gn3d_fade (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [gn3d_pkg::FracBits-1:0]  t,
    output logic [gn3d_pkg::FracBits:0]    f
);
    import gn3d_pkg::*;

    logic signed [23:0] t1_reg, tt_reg, a_reg, t2_reg, t3_reg, b_reg, bb_reg;
    logic [FracBits:0] f_reg;
    logic signed [47:0] p0, p1, p2, p3;
    logic signed [47:0] r3;

    // b needs one extra stage to align with t^3
    always_comb begin
        p0 = $signed({1'b0, t1_reg}) * $signed({1'b0, t1_reg});
        p1 = t1_reg * a_reg;
        p2 = tt_reg * t2_reg;
        p3 = t3_reg * bb_reg;
        r3 = rnd_shift(p3);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg  <= {8'd0, t};
            a_reg   <= 24'(6 * {8'd0, t}) - 24'(15 << FracBits);
            tt_reg  <= 24'(rnd_shift(p0));
            b_reg   <= 24'(rnd_shift(p1)) + 24'(10 << FracBits);
            t2_reg  <= t1_reg;
            t3_reg  <= 24'(rnd_shift(p2));
            bb_reg  <= b_reg;
            if (r3 < 0)
                f_reg <= '0;
            else if (r3 > (48'sd1 <<< FracBits))
                f_reg <= (FracBits+1)'(1 << FracBits);
            else
                f_reg <= r3[FracBits:0];
        end
    end
    assign f = f_reg;
endmodule

@@ rtl/gn3d_core.sv @@
// noise pipeline: table lookup, gradients, fade and trilinear blend
// depends on gn3d_pkg and gn3d_fade
module gn3d_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic                            in_mode,
    input  logic [gn3d_pkg::CoordW-1:0]     in_x,
    input  logic [gn3d_pkg::CoordW-1:0]     in_y,
    input  logic [gn3d_pkg::CoordW-1:0]     in_z,
    input  gn3d_pkg::idx_t                  in_index,
    input  gn3d_pkg::idx_t                  in_value,
    output logic                            out_valid,
    output logic signed [gn3d_pkg::OutW-1:0] out_noise
);
    import gn3d_pkg::*;

    // permutation table, two reads per copy, 1/2/4 copies in stages 1/2/3; a
    // table write walks down the pipeline and lands in each copy as it passes
    logic [7:0] perm_s1 [TableSize];
    logic [7:0] perm_s2 [2][TableSize];
    logic [3:0] perm_s3 [4][TableSize];

    logic [PipeDepth-1:0] v_reg;
    logic [2:0] wv_reg;
    idx_t widx_reg [3];
    idx_t wval_reg [3];
    logic [FracBits-1:0] fx_reg [4];
    logic [FracBits-1:0] fy_reg [4];
    logic [FracBits-1:0] fz_reg [4];
    idx_t cx_reg;
    idx_t cy_reg [2];
    idx_t cz_reg [3];
    idx_t r1_reg [2];
    idx_t r2_reg [4];
    idx_t ad2 [2];
    idx_t ad3 [4];
    logic [3:0] h_reg [8];
    val_t g_reg [8];
    val_t l1_reg [4], d1_reg [4], l1a_reg [4];
    val_t l2_reg [2], d2_reg [2], l2a_reg [2];
    val_t l3_reg, d3_reg;
    val_t rz;
    logic [FracBits:0] fu, fv, fw;
    logic [FracBits:0] fu_reg;
    logic [FracBits:0] fv_reg [3];
    logic [FracBits:0] fw_reg [5];
    logic signed [OutW-1:0] o_reg;
    val_t xs [2], ys [2], zs [2];

    gn3d_fade u_fu (.aclk(aclk), .en(en), .t(fx_reg[0]), .f(fu));
    gn3d_fade u_fv (.aclk(aclk), .en(en), .t(fy_reg[0]), .f(fv));
    gn3d_fade u_fw (.aclk(aclk), .en(en), .t(fz_reg[0]), .f(fw));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            wv_reg <= '0;
        end else if (en) begin
            v_reg  <= {v_reg[PipeDepth-2:0], in_valid && in_mode == MODE_EVAL};
            wv_reg <= {wv_reg[1:0], in_valid && in_mode == MODE_WRITE};
        end
    end

    // r2 is ordered by corner: perm(a), perm(b), perm(a+1), perm(b+1)
    always_comb begin
        for (int j = 0; j < 2; j++)
            ad2[j] = r1_reg[j] + cy_reg[1];
        for (int c = 0; c < 4; c++)
            ad3[c] = r2_reg[c] + cz_reg[2];
    end

    // stage 1: a, b sources
    always_ff @(posedge aclk) begin
        if (en) begin
            if (wv_reg[0])
                perm_s1[widx_reg[0]] <= wval_reg[0];
            r1_reg[0] <= perm_s1[cx_reg];
            r1_reg[1] <= perm_s1[cx_reg + idx_t'(1)];
        end
    end

    // stage 2: second level hashes
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 2; j++) begin
                if (wv_reg[1])
                    perm_s2[j][widx_reg[1]] <= wval_reg[1];
                r2_reg[j]   <= perm_s2[j][ad2[j]];
                r2_reg[j+2] <= perm_s2[j][ad2[j] + idx_t'(1)];
            end
        end
    end

    // stage 3: corner hashes, index bit0=x bit1=y bit2=z
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                if (wv_reg[2])
                    perm_s3[c][widx_reg[2]] <= wval_reg[2][3:0];
                h_reg[c]   <= perm_s3[c][ad3[c]];
                h_reg[c+4] <= perm_s3[c][ad3[c] + idx_t'(1)];
            end
        end
    end

    always_comb begin
        xs[0] = val_t'({1'b0, fx_reg[3]}); xs[1] = xs[0] - val_t'(1 << FracBits);
        ys[0] = val_t'({1'b0, fy_reg[3]}); ys[1] = ys[0] - val_t'(1 << FracBits);
        zs[0] = val_t'({1'b0, fz_reg[3]}); zs[1] = zs[0] - val_t'(1 << FracBits);
        rz = l3_reg + val_t'(rnd_shift($signed({1'b0, fw_reg[4]}) * 48'(d3_reg)));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 0: split coordinates
            fx_reg[0] <= in_x[FracBits-1:0];
            fy_reg[0] <= in_y[FracBits-1:0];
            fz_reg[0] <= in_z[FracBits-1:0];
            cx_reg    <= in_x[FracBits +: TableBits];
            cy_reg[0] <= in_y[FracBits +: TableBits];
            cz_reg[0] <= in_z[FracBits +: TableBits];
            widx_reg[0] <= in_index;
            wval_reg[0] <= in_value;
            for (int i = 1; i < 4; i++) begin
                fx_reg[i] <= fx_reg[i-1];
                fy_reg[i] <= fy_reg[i-1];
                fz_reg[i] <= fz_reg[i-1];
            end
            for (int i = 1; i < 3; i++) begin
                widx_reg[i] <= widx_reg[i-1];
                wval_reg[i] <= wval_reg[i-1];
                cz_reg[i]   <= cz_reg[i-1];
            end
            cy_reg[1] <= cy_reg[0];
            // stage 4: gradients; fades ready here
            for (int i = 0; i < 8; i++)
                g_reg[i] <= grad(h_reg[i], xs[i[0]], ys[i[1]], zs[i[2]]);
            // stage 5: differences along x
            for (int i = 0; i < 4; i++) begin
                l1_reg[i] <= g_reg[2*i];
                d1_reg[i] <= g_reg[2*i+1] - g_reg[2*i];
            end
            fu_reg <= fu;
            fv_reg[0] <= fv;
            fw_reg[0] <= fw;
            for (int i = 1; i < 3; i++) fv_reg[i] <= fv_reg[i-1];
            for (int i = 1; i < 5; i++) fw_reg[i] <= fw_reg[i-1];
            // stage 6: x blend
            for (int i = 0; i < 4; i++)
                l1a_reg[i] <= l1_reg[i] + val_t'(rnd_shift(
                    $signed({1'b0, fu_reg}) * 48'(d1_reg[i])));
            // stage 7: y differences
            for (int i = 0; i < 2; i++) begin
                l2_reg[i] <= l1a_reg[2*i];
                d2_reg[i] <= l1a_reg[2*i+1] - l1a_reg[2*i];
            end
            // stage 8: y blend
            for (int i = 0; i < 2; i++)
                l2a_reg[i] <= l2_reg[i] + val_t'(rnd_shift(
                    $signed({1'b0, fv_reg[2]}) * 48'(d2_reg[i])));
            // stage 9: z difference
            l3_reg <= l2a_reg[0];
            d3_reg <= l2a_reg[1] - l2a_reg[0];
            // stage 10: z blend and saturate
            if (rz > OutMax)
                o_reg <= OutMax[OutW-1:0];
            else if (rz < OutMin)
                o_reg <= OutMin[OutW-1:0];
            else
                o_reg <= rz[OutW-1:0];
        end
    end

    assign out_valid = v_reg[PipeDepth-1];
    assign out_noise = o_reg;
endmodule

@@ rtl/gradient_noise_3d_unit.sv @@
// top level of the 3d gradient noise unit: pipeline plus output skid stage
// depends on gn3d_pkg and gn3d_core
//
// usage: s_ channel carries one beat per item. mode 1 writes table_value into
// permutation entry table_index and gives no result; mode 0 evaluates noise
// at (coord_x, coord_y, coord_z), signed Q8.16, and gives one m_noise_value
// beat, signed Q2.16, saturated.
// throughput: one item per cycle while the output does not stall.
// the table must be loaded before points that read it are sent; a table
// write takes effect for items accepted after it.
// the whole pipeline advances as one; if the receiver stalls, the output slot
// is full and a result waits, s_ready drops, every stage holds, none is lost.
// reset (aresetn low, synchronous) clears all valid bits; the table keeps
// its contents and is undefined until written.
module gradient_noise_3d_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic signed [gn3d_pkg::CoordW-1:0] s_coord_x,
    input  logic signed [gn3d_pkg::CoordW-1:0] s_coord_y,
    input  logic signed [gn3d_pkg::CoordW-1:0] s_coord_z,
    input  logic [7:0]                        s_table_index,
    input  logic [7:0]                        s_table_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [gn3d_pkg::OutW-1:0]  m_noise_value
);
    import gn3d_pkg::*;

    logic en, pv;
    logic signed [OutW-1:0] pn;
    logic full_reg;
    logic signed [OutW-1:0] data_reg;

    // pipeline moves unless its finished beat cannot leave
    assign en = !(pv && full_reg && !m_ready);
    assign s_ready = en && aresetn;

    gn3d_core u_core (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid), .in_mode(s_mode),
        .in_x(s_coord_x), .in_y(s_coord_y), .in_z(s_coord_z),
        .in_index(s_table_index), .in_value(s_table_value),
        .out_valid(pv), .out_noise(pn)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn)
            full_reg <= 1'b0;
        else if (pv && en)
            full_reg <= 1'b1;
        else if (m_ready)
            full_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (pv && en)
            data_reg <= pn;
    end

    assign m_valid = full_reg;
    assign m_noise_value = data_reg;
endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// testbench for gradient_noise_3d_unit: loads the permutation table, then
// drives directed and random points and checks each result against a predictor
// depends on gn3d_pkg and the rtl of gradient_noise_3d_unit
module tb;
    import gn3d_pkg::*;

    typedef struct {
        logic              mode;
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic signed [23:0] cz;
        logic [7:0]        tidx;
        logic [7:0]        tval;
    } noise_req_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_mode = MODE_WRITE;
    logic signed [23:0] s_coord_x = '0;
    logic signed [23:0] s_coord_y = '0;
    logic signed [23:0] s_coord_z = '0;
    logic [7:0] s_table_index = '0;
    logic [7:0] s_table_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [17:0] m_noise_value;

    noise_req_t pending_reqs[$];
    logic signed [17:0] expected_noise[$];
    logic [7:0] perm_copy[256];
    int error_count = 0;
    int cycle_count = 0;
    int send_wait = 0;
    int recv_wait = 0;
    bit hold_for_drain = 1'b0;
    bit stim_done = 1'b0;

    gradient_noise_3d_unit dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic longint round16(input longint p);
        return (p + 32768) >>> 16;
    endfunction

    function automatic longint fade_curve(input longint t);
        longint b;
        longint f;
        b = round16(t * (6 * t - 15 * 65536)) + 10 * 65536;
        f = round16(round16(round16(t * t) * t) * b);
        if (f < 0) f = 0;
        if (f > 65536) f = 65536;
        return f;
    endfunction

    function automatic longint lerp16(input longint t, input longint a, input longint b);
        return a + round16(t * (b - a));
    endfunction

    function automatic longint corner_dot(input logic [7:0] hash, input longint x,
                                          input longint y, input longint z);
        logic [3:0] h;
        longint u;
        longint v;
        h = hash[3:0];
        u = (h < 8) ? x : y;
        v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic logic signed [17:0] predict_noise(input noise_req_t r);
        logic [7:0] ix, iy, iz, a, aa, ab, b, ba, bb;
        longint x, y, z, x1, y1, z1, u, v, w, lo, hi;
        ix = r.cx[23:16]; iy = r.cy[23:16]; iz = r.cz[23:16];
        x = r.cx[15:0]; y = r.cy[15:0]; z = r.cz[15:0];
        x1 = x - 65536; y1 = y - 65536; z1 = z - 65536;
        u = fade_curve(x); v = fade_curve(y); w = fade_curve(z);
        a = perm_copy[ix] + iy;
        aa = perm_copy[a] + iz;
        ab = perm_copy[8'(a + 1)] + iz;
        b = perm_copy[8'(ix + 1)] + iy;
        ba = perm_copy[b] + iz;
        bb = perm_copy[8'(b + 1)] + iz;
        lo = lerp16(v, lerp16(u, corner_dot(perm_copy[aa], x, y, z),
                                 corner_dot(perm_copy[ba], x1, y, z)),
                       lerp16(u, corner_dot(perm_copy[ab], x, y1, z),
                                 corner_dot(perm_copy[bb], x1, y1, z)));
        hi = lerp16(v, lerp16(u, corner_dot(perm_copy[8'(aa + 1)], x, y, z1),
                                 corner_dot(perm_copy[8'(ba + 1)], x1, y, z1)),
                       lerp16(u, corner_dot(perm_copy[8'(ab + 1)], x, y1, z1),
                                 corner_dot(perm_copy[8'(bb + 1)], x1, y1, z1)));
        lo = lerp16(w, lo, hi);
        if (lo > 131071) lo = 131071;
        if (lo < -131072) lo = -131072;
        return 18'(lo);
    endfunction

    function automatic noise_req_t make_point(input int x, input int y, input int z);
        noise_req_t r;
        r.mode = MODE_EVAL;
        r.cx = 24'(x); r.cy = 24'(y); r.cz = 24'(z);
        r.tidx = 8'($urandom); r.tval = 8'($urandom);
        return r;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 8388607 : -8388608;
            1: return $urandom_range(0, 3) * 65536 - 65536 * $urandom_range(0, 2);
            2: return int'(24'($urandom)) & 32'h00ff_ffff | ($urandom_range(0, 1) ? -16777216 : 0);
            default: return int'({{8{1'b0}}, 24'($urandom)}) - 8388608;
        endcase
    endfunction

    // driver; mode 1 beats update the predictor's table as they are accepted
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (s_mode == MODE_WRITE) begin
                    perm_copy[s_table_index] = s_table_value;
                end else begin
                    expected_noise.push_back(predict_noise('{s_mode, s_coord_x, s_coord_y,
                        s_coord_z, s_table_index, s_table_value}));
                end
            end
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    s_valid <= 1'b0;
                    send_wait <= send_wait - 1;
                end else if (hold_for_drain && expected_noise.size() != 0) begin
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    noise_req_t r;
                    r = pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_mode <= r.mode;
                    s_coord_x <= r.cx; s_coord_y <= r.cy; s_coord_z <= r.cz;
                    s_table_index <= r.tidx; s_table_value <= r.tval;
                    send_wait <= (cycle_count % 700 < 100) ? 0 : $urandom_range(0, 9);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_noise.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat %0d", m_noise_value));
                end else begin
                    logic signed [17:0] e;
                    e = expected_noise.pop_front();
                    if (e !== m_noise_value)
                        report_mismatch($sformatf("noise_value got %0d want %0d",
                                                  m_noise_value, e));
                end
                recv_wait <= (cycle_count % 900 < 150) ? 0 : $urandom_range(0, 9);
                m_ready <= (cycle_count % 900 < 150);
            end else if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        noise_req_t r;
        int order[256];
        int drain;
        for (int i = 0; i < 256; i++) order[i] = i;
        order.shuffle();
        // full table load, index also walks both bit values of every bit
        for (int i = 0; i < 256; i++) begin
            r = make_point(0, 0, 0);
            r.mode = MODE_WRITE; r.tidx = 8'(i); r.tval = 8'(order[i]);
            pending_reqs.push_back(r);
        end
        pending_reqs.push_back(make_point(0, 0, 0));
        pending_reqs.push_back(make_point(8388607, 8388607, 8388607));
        pending_reqs.push_back(make_point(-8388608, -8388608, -8388608));
        pending_reqs.push_back(make_point(-1, -1, -1));
        pending_reqs.push_back(make_point(65535, 0, -65536));
        pending_reqs.push_back(make_point(32768, 32768, 32768));
        pending_reqs.push_back(make_point(-32768, 98304, 16777215 - 8388607 * 2));
        pending_reqs.push_back(make_point(8388607, -8388608, 0));
        r = make_point(0, 0, 0); r.mode = MODE_WRITE; r.tidx = 8'd255; r.tval = 8'd0;
        pending_reqs.push_back(r);
        r.tidx = 8'd0; r.tval = 8'd255;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_point(-65536, 65536 * 255, 12345));
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        // a drain pause midway through the random part
        for (int i = 0; i < 1630; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                r = make_point(0, 0, 0); r.mode = MODE_WRITE;
            end else begin
                r = make_point(rand_coord(), rand_coord(), rand_coord());
            end
            pending_reqs.push_back(r);
            if (i == 900) begin
                wait (pending_reqs.size() == 0 && !s_valid);
                hold_for_drain = 1'b1;
                wait (expected_noise.size() == 0);
                hold_for_drain = 1'b0;
            end
        end
        wait (pending_reqs.size() == 0 && !s_valid);
        wait (expected_noise.size() == 0);
        drain = 0;
        while (drain < 40) begin
            @(posedge aclk);
            drain++;
        end
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done || cycle_count > 200000);
        if (!stim_done) begin
            $display("Testbench completed WITH ERRORS");
        end else if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

@@ gradient_noise_3d_unit.f @@
rtl/gn3d_pkg.sv
rtl/gn3d_fade.sv
rtl/gn3d_core.sv
rtl/gradient_noise_3d_unit.sv
tb/sv/tb.sv
